// ===== hdl/dual_spi_register_slave_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the dual SPI register slave
// Concurrent checks sampled on clk and switched off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef DUAL_SPI_REGISTER_SLAVE_MACROS_SVH
`define DUAL_SPI_REGISTER_SLAVE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DSPI_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DSPI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/dspi_pkg.sv =====
// ----------------------------------------------------------------------------
// dspi_pkg
// Shared types and constants of the dual SPI register slave.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dspi_pkg;

	localparam int STORE_AW = 9;

	typedef enum logic [1:0] {
		CMD_SELECT   = 2'd0,
		CMD_DESELECT = 2'd1,
		CMD_WRITE    = 2'd2,
		CMD_READ     = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		SEL_NONE = 2'd0,
		SEL_TEXT = 2'd1,
		SEL_A    = 2'd2,
		SEL_B    = 2'd3
	} sel_t;

	typedef enum logic [1:0] {
		MODE_WRITE  = 2'd0,
		MODE_READ   = 2'd1,
		MODE_IGNORE = 2'd2
	} mode_t;

	// Highest valid device code on a select transfer (device B).
	localparam logic [1:0] DEV_MAX = 2'd2;

	// Command byte decoding.
	localparam logic [7:0] A_WRITE_LO  = 8'h20;
	localparam logic [7:0] A_IGNORE_LO = 8'h40;
	localparam logic [7:0] A_ADDR_MASK = 8'h1F;
	localparam logic [7:0] B_READ_BIT  = 8'h80;
	localparam logic [7:0] STATUS_BYTE = 8'h00;

	// Store access issued by an accepted transfer.
	typedef struct packed {
		logic                we;
		logic                re;
		logic [STORE_AW-1:0] addr;
		logic [7:0]          wdata;
	} mem_req_t;

	// What the output stage needs to finish a transfer.
	typedef struct packed {
		logic       is_read;
		logic       mem_read;
		logic       status;
		logic       text_valid;
		logic [7:0] text_char;
	} item_info_t;

endpackage

`default_nettype wire

// ===== hdl/dspi_ram.sv =====
// ----------------------------------------------------------------------------
// dspi_ram
// Simple dual-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dspi_ram #(
	parameter int WIDTH  = 8,
	parameter int ADDR_W = 9
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output      logic [WIDTH-1:0]  rdata
);

	localparam int DEPTH = 1 << ADDR_W;

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hdl/dspi_ctrl.sv =====
// ----------------------------------------------------------------------------
// dspi_ctrl
// Transaction state, command decoding and store address generation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dspi_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 accept,
	input  wire logic [1:0]           command,
	input  wire logic [1:0]           device,
	input  wire logic [7:0]           data_byte,
	output      dspi_pkg::mem_req_t   req,
	output      dspi_pkg::item_info_t info
);

	dspi_pkg::sel_t  sel_q, sel_d;
	logic            taken_q, taken_d;
	logic            status_q, status_d;
	dspi_pkg::mode_t mode_q [2];
	dspi_pkg::mode_t mode_d [2];
	logic [7:0]      rp_q [2];
	logic [7:0]      rp_d [2];
	logic [7:0]      wp_q [2];
	logic [7:0]      wp_d [2];
	logic            is_reg;
	logic            dev;

	always_comb begin
		is_reg = (sel_q == dspi_pkg::SEL_A) || (sel_q == dspi_pkg::SEL_B);
		dev    = (sel_q == dspi_pkg::SEL_B);

		sel_d    = sel_q;
		taken_d  = taken_q;
		status_d = status_q;
		mode_d   = mode_q;
		rp_d     = rp_q;
		wp_d     = wp_q;

		req.we    = 1'b0;
		req.re    = 1'b0;
		req.addr  = '0;
		req.wdata = data_byte;

		info.is_read    = 1'b0;
		info.mem_read   = 1'b0;
		info.status     = 1'b0;
		info.text_valid = 1'b0;
		info.text_char  = '0;

		case (dspi_pkg::cmd_t'(command))
			dspi_pkg::CMD_SELECT: begin
				if (device <= dspi_pkg::DEV_MAX) begin
					sel_d    = dspi_pkg::sel_t'(2'(device + 2'd1));
					taken_d  = 1'b0;
					status_d = 1'b0;
				end
			end
			dspi_pkg::CMD_DESELECT: begin
				sel_d = dspi_pkg::SEL_NONE;
			end
			dspi_pkg::CMD_WRITE: begin
				if (sel_q == dspi_pkg::SEL_TEXT) begin
					info.text_valid = 1'b1;
					info.text_char  = data_byte;
				end else if (is_reg) begin
					if (!taken_q) begin
						taken_d = 1'b1;
						if (!dev) begin
							if (data_byte < dspi_pkg::A_WRITE_LO) begin
								mode_d[0] = dspi_pkg::MODE_READ;
								rp_d[0]   = data_byte;
							end else if (data_byte < dspi_pkg::A_IGNORE_LO) begin
								mode_d[0] = dspi_pkg::MODE_WRITE;
								wp_d[0]   = data_byte & dspi_pkg::A_ADDR_MASK;
							end else begin
								mode_d[0] = dspi_pkg::MODE_IGNORE;
							end
						end else begin
							if ((data_byte & dspi_pkg::B_READ_BIT) != 8'h00) begin
								mode_d[1] = dspi_pkg::MODE_READ;
								rp_d[1]   = data_byte;
							end else begin
								mode_d[1] = dspi_pkg::MODE_WRITE;
								wp_d[1]   = data_byte | dspi_pkg::B_READ_BIT;
							end
						end
					end else if (mode_q[dev] == dspi_pkg::MODE_WRITE) begin
						req.we      = 1'b1;
						req.addr    = {dev, wp_q[dev]};
						wp_d[dev]   = 8'(wp_q[dev] + 8'd1);
					end
				end
			end
			dspi_pkg::CMD_READ: begin
				info.is_read = 1'b1;
				if (is_reg && taken_q && (mode_q[dev] == dspi_pkg::MODE_READ)) begin
					if (!status_q) begin
						status_d    = 1'b1;
						info.status = 1'b1;
					end else begin
						req.re        = 1'b1;
						req.addr      = {dev, rp_q[dev]};
						info.mem_read = 1'b1;
						rp_d[dev]     = 8'(rp_q[dev] + 8'd1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q     <= dspi_pkg::SEL_NONE;
			taken_q   <= 1'b0;
			status_q  <= 1'b0;
			mode_q[0] <= dspi_pkg::MODE_WRITE;
			mode_q[1] <= dspi_pkg::MODE_WRITE;
			rp_q[0]   <= '0;
			rp_q[1]   <= '0;
			wp_q[0]   <= '0;
			wp_q[1]   <= '0;
		end else if (accept) begin
			sel_q    <= sel_d;
			taken_q  <= taken_d;
			status_q <= status_d;
			mode_q   <= mode_d;
			rp_q     <= rp_d;
			wp_q     <= wp_d;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/dual_spi_register_slave.sv =====
// A transfer passes through stage one and then the output register. Throughput: one
// transfer per cycle unless a held result stalls the output; the store's single read and write port suffice.
// Reset: all control state clears at once, then a clearing pass writes zero into the
// 512-entry store one entry per cycle, so in_ready stays low until every entry is cleared.
// The result register lets a new transfer enter while the previous result waits.
// ----------------------------------------------------------------------------
// dual_spi_register_slave
// Three SPI slaves on one byte port: a text sink and two register devices.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "dual_spi_register_slave_macros.svh"

module dual_spi_register_slave (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output      logic       in_ready,
	input  wire logic [1:0] command,
	input  wire logic [1:0] device,
	input  wire logic [7:0] data_byte,
	output      logic       out_valid,
	input  wire logic       out_ready,
	output      logic [7:0] read_data,
	output      logic       text_valid,
	output      logic [7:0] text_char
);

	// Clearing pass over the store after reset.
	logic                          clr_q;
	logic [dspi_pkg::STORE_AW-1:0] clr_addr_q;

	// Transfer decode and store access.
	logic                 accept;
	dspi_pkg::mem_req_t   req;
	dspi_pkg::item_info_t info;
	logic                 ram_we;
	logic                 ram_re;
	logic [dspi_pkg::STORE_AW-1:0] ram_waddr;
	logic [7:0]           ram_wdata;
	logic [7:0]           ram_rdata;

	// Stage one waits for the store read data; the output register follows it.
	logic                 v_s1;
	dspi_pkg::item_info_t info_s1;
	logic                 s1_move;
	logic                 out_valid_q;
	logic [7:0]           read_data_q;
	logic                 text_valid_q;
	logic [7:0]           text_char_q;

	// The byte last returned by a store or status read; only reads change it.
	logic [7:0]           held_q;
	logic [7:0]           held_next;

	assign s1_move  = v_s1 && (!out_valid_q || out_ready);
	assign in_ready = !clr_q && (!v_s1 || s1_move);
	assign accept   = in_valid && in_ready;

	dspi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.command   (command),
		.device    (device),
		.data_byte (data_byte),
		.req       (req),
		.info      (info)
	);

	// During the clearing pass the write port belongs to the sweep. A transfer only
	// ever writes or reads, so the two ports never touch one entry in one cycle, and a
	// read of an entry written by the preceding transfer already sees the new byte.
	assign ram_we    = clr_q || (accept && req.we);
	assign ram_waddr = clr_q ? clr_addr_q : req.addr;
	assign ram_wdata = clr_q ? 8'h00 : req.wdata;
	assign ram_re    = accept && req.re;

	dspi_ram #(
		.WIDTH  (8),
		.ADDR_W (dspi_pkg::STORE_AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (req.addr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == '1) begin
				clr_q <= 1'b0;
			end
		end
	end

	// The RAM read data is held while stage one stalls, because no new transfer is
	// accepted (and so no read issued) until stage one moves on.
	always_comb begin
		if (info_s1.mem_read) begin
			held_next = ram_rdata;
		end else if (info_s1.status) begin
			held_next = dspi_pkg::STATUS_BYTE;
		end else begin
			held_next = held_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
			held_q      <= 8'h00;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (s1_move) begin
				v_s1 <= 1'b0;
			end
			if (s1_move) begin
				out_valid_q <= 1'b1;
				held_q      <= held_next;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			info_s1 <= info;
		end
		if (s1_move) begin
			read_data_q  <= info_s1.is_read ? held_next : 8'h00;
			text_valid_q <= info_s1.text_valid;
			text_char_q  <= info_s1.text_char;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_data  = read_data_q;
	assign text_valid = text_valid_q;
	assign text_char  = text_char_q;

	// No transfer may enter while the store is still being cleared.
	`DSPI_ASSERT_SAME(a_no_accept_in_clear, clr_q, !in_ready, "transfer accepted during clear")
	// A transfer never reads and writes the store at once.
	`DSPI_ASSERT_SAME(a_no_rw_overlap, accept, !(req.we && req.re), "store read and write together")
	// A stalled stage one keeps its transfer.
	`DSPI_ASSERT_NEXT(a_s1_hold, v_s1 && !s1_move, v_s1, "stage one lost a transfer")
	// Text output only comes from write transfers, which return no port byte.
	`DSPI_ASSERT_SAME(a_text_no_read, out_valid && text_valid, read_data == 8'h00,
		"text result carries read data")

endmodule

`default_nettype wire
